FILE: sv/fifo_handoff_mutex_top_macros.svh
// ---------------------------------------------------------------------------
// fifo_handoff_mutex_top_macros
// Assertion macros used by the mutex core (fhm_core).
// ---------------------------------------------------------------------------
`ifndef FIFO_HANDOFF_MUTEX_TOP_MACROS_SVH
`define FIFO_HANDOFF_MUTEX_TOP_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define FHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the active-low reset.
`define FHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/fhm_pkg.sv
// ---------------------------------------------------------------------------
// fhm_pkg
// Types, constants and helpers of the FIFO hand-off mutex.
// ---------------------------------------------------------------------------
package fhm_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int TASK_W      = 4;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		KIND_LOCK   = 1'b0,
		KIND_UNLOCK = 1'b1
	} fhm_kind_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_FULL      = 3'd2,
		ST_FREED     = 3'd3,
		ST_HANDED    = 3'd4,
		ST_NOT_OWNER = 3'd5
	} fhm_status_t;

	typedef enum logic {
		FHM_IDLE,
		FHM_EXEC
	} fhm_state_t;

	// Queue memory access, core to RAM.
	typedef struct packed {
		logic              wr_en;
		logic [PTR_W-1:0]  wr_addr;
		logic [TASK_W-1:0] wr_data;
		logic              rd_en;
		logic [PTR_W-1:0]  rd_addr;
	} fhm_ram_req_t;

	// One finished result, core to output register.
	typedef struct packed {
		logic              load;
		fhm_status_t       status;
		logic              woken_valid;
		logic [TASK_W-1:0] woken_task;
	} fhm_result_t;

	// Advance a ring pointer, wrapping at the queue depth.
	function automatic logic [PTR_W-1:0] fhm_ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: sv/fhm_ram.sv
// ---------------------------------------------------------------------------
// fhm_ram
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module fhm_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/fhm_core.sv
// ---------------------------------------------------------------------------
// fhm_core
// Mutex state, ring-buffer pointers and the request sequencer.
// ---------------------------------------------------------------------------
`include "fifo_handoff_mutex_top_macros.svh"

module fhm_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [fhm_pkg::TASK_W-1:0]   task_id,
	input  logic                         out_free,
	output fhm_pkg::fhm_ram_req_t        ram_req,
	input  logic [fhm_pkg::TASK_W-1:0]   rd_data,
	output fhm_pkg::fhm_result_t         res
);

	fhm_pkg::fhm_state_t state_q, state_d;

	logic                        kind_s1;
	logic [fhm_pkg::TASK_W-1:0]  task_s1;

	logic                        held_q;
	logic [fhm_pkg::TASK_W-1:0]  holder_q;
	logic [fhm_pkg::CNT_W-1:0]   count_q;
	logic [fhm_pkg::PTR_W-1:0]   head_q;
	logic [fhm_pkg::PTR_W-1:0]   tail_q;

	logic accept;
	logic exec_go;

	// Sequencer: take a request, then finish it once the head entry is read and the result register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhm_pkg::FHM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		exec_go  = 1'b0;
		unique case (state_q)
			fhm_pkg::FHM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = fhm_pkg::FHM_EXEC;
				end
			end
			fhm_pkg::FHM_EXEC: begin
				if (out_free) begin
					exec_go = 1'b1;
					state_d = fhm_pkg::FHM_IDLE;
				end
			end
			default: begin
				state_d = fhm_pkg::FHM_IDLE;
			end
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			task_s1 <= task_id;
		end
	end

	// Decide the outcome from the state and the prefetched head entry.
	always_comb begin
		res             = '0;
		res.load        = exec_go;
		res.status      = fhm_pkg::ST_GRANTED;
		ram_req         = '0;
		ram_req.rd_en   = accept;
		ram_req.rd_addr = head_q;
		ram_req.wr_addr = tail_q;
		ram_req.wr_data = task_s1;
		if (kind_s1 == fhm_pkg::KIND_LOCK) begin
			priority if (!held_q || holder_q == task_s1) begin
				res.status = fhm_pkg::ST_GRANTED;
			end else if (count_q == fhm_pkg::CNT_W'(fhm_pkg::QUEUE_DEPTH)) begin
				res.status = fhm_pkg::ST_FULL;
			end else begin
				res.status    = fhm_pkg::ST_QUEUED;
				ram_req.wr_en = exec_go;
			end
		end else begin
			priority if (!held_q || holder_q != task_s1) begin
				res.status = fhm_pkg::ST_NOT_OWNER;
			end else if (count_q == '0) begin
				res.status = fhm_pkg::ST_FREED;
			end else begin
				res.status      = fhm_pkg::ST_HANDED;
				res.woken_valid = 1'b1;
				res.woken_task  = rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			holder_q <= '0;
			count_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
		end else if (exec_go) begin
			unique case (res.status)
				fhm_pkg::ST_GRANTED: begin
					held_q   <= 1'b1;
					holder_q <= task_s1;
				end
				fhm_pkg::ST_QUEUED: begin
					tail_q  <= fhm_pkg::fhm_ptr_next(tail_q);
					count_q <= count_q + 1'b1;
				end
				fhm_pkg::ST_FREED: begin
					held_q   <= 1'b0;
					holder_q <= '0;
				end
				fhm_pkg::ST_HANDED: begin
					holder_q <= rd_data;
					head_q   <= fhm_pkg::fhm_ptr_next(head_q);
					count_q  <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	`FHM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= fhm_pkg::CNT_W'(fhm_pkg::QUEUE_DEPTH), "wait count above queue depth")
	`FHM_ASSERT_NOW(a_waiters_need_holder, clk, arst_n, count_q != '0, held_q, "waiters on a free mutex")
	`FHM_ASSERT_NOW(a_free_holder_zero, clk, arst_n, !held_q, holder_q == '0, "free mutex keeps a holder id")
	`FHM_ASSERT_NXT(a_handover_pops, clk, arst_n, exec_go && res.status == fhm_pkg::ST_HANDED, count_q == $past(count_q) - 1'b1, "handover did not pop the queue")
	`FHM_ASSERT_NOW(a_no_accept_busy, clk, arst_n, state_q == fhm_pkg::FHM_EXEC, !accept, "request taken while one is in flight")

endmodule

FILE: sv/fifo_handoff_mutex_top.sv
// ---------------------------------------------------------------------------
// fifo_handoff_mutex_top
// Hardware mutex with a first-in-first-out wait queue.
// ---------------------------------------------------------------------------
// Each request transfer is a lock or unlock from one task id and yields
// exactly one result transfer. A lock on a free mutex, or by the current
// holder, is granted; otherwise the task joins the wait queue, or is refused
// when the queue is full. An unlock by the holder frees the mutex or hands it
// straight to the oldest waiter (woken_valid/woken_task); any other unlock
// reports not owner. A request first reads the queue head from the waiter
// memory (registered read port), then decides, updates the state and loads
// the result register. The next request is taken as soon as that result is
// loaded, even while the result itself still waits under out_stall; a full
// result register that stays stalled holds the decide step. Waiters live in
// a ring buffer; no clearing pass runs after reset.
// ---------------------------------------------------------------------------
module fifo_handoff_mutex_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [fhm_pkg::TASK_W-1:0] task_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 status,
	output logic                       woken_valid,
	output logic [fhm_pkg::TASK_W-1:0] woken_task
);

	fhm_pkg::fhm_ram_req_t       ram_req;
	fhm_pkg::fhm_result_t        res;
	logic [fhm_pkg::TASK_W-1:0]  rd_data;
	logic                        out_free;

	logic                        out_valid_q;
	fhm_pkg::fhm_status_t        status_q;
	logic                        woken_valid_q;
	logic [fhm_pkg::TASK_W-1:0]  woken_task_q;

	// The result register may take a new result when empty or when its
	// current one transfers at this edge.
	assign out_free = !out_valid_q || !out_stall;

	fhm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.task_id  (task_id),
		.out_free (out_free),
		.ram_req  (ram_req),
		.rd_data  (rd_data),
		.res      (res)
	);

	// Waiter ring buffer: write at the tail, prefetch at the head.
	fhm_ram #(
		.DEPTH (fhm_pkg::QUEUE_DEPTH),
		.WIDTH (fhm_pkg::TASK_W)
	) u_queue (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	// Hold the result until its transfer; load a fresh one when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q      <= res.status;
			woken_valid_q <= res.woken_valid;
			woken_task_q  <= res.woken_task;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign woken_valid = woken_valid_q;
	assign woken_task  = woken_task_q;

endmodule

FILE: tb/fhm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhm_checker
// Watches both channels of the FIFO hand-off mutex, keeps its own copy of the
// lock and wait queue state, and compares every result transfer field by
// field with the oldest expected reply.
// ---------------------------------------------------------------------------
module fhm_checker
	import fhm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [TASK_W-1:0] task_id,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [2:0]        status,
	input  logic              woken_valid,
	input  logic [TASK_W-1:0] woken_task,
	output int                fails,
	output int                pending
);

	typedef struct packed {
		fhm_status_t       status;
		logic              woken_valid;
		logic [TASK_W-1:0] woken_task;
	} mutex_reply_t;

	mutex_reply_t      replies_due[$];
	logic [TASK_W-1:0] waiters[$];
	logic              lock_held;
	logic [TASK_W-1:0] lock_owner;

	// Apply one request to the shadow mutex and return its reply.
	function automatic mutex_reply_t arbitrate(fhm_kind_t req, logic [TASK_W-1:0] id);
		mutex_reply_t r;
		r = '0;
		if (req == KIND_LOCK) begin
			if (!lock_held) begin
				lock_held  = 1'b1;
				lock_owner = id;
				r.status   = ST_GRANTED;
			end else if (lock_owner == id) begin
				r.status = ST_GRANTED;
			end else if (waiters.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				waiters.push_back(id);
				r.status = ST_QUEUED;
			end
		end else begin
			if (!lock_held || lock_owner != id) begin
				r.status = ST_NOT_OWNER;
			end else if (waiters.size() == 0) begin
				lock_held  = 1'b0;
				lock_owner = '0;
				r.status   = ST_FREED;
			end else begin
				r.woken_task  = waiters.pop_front();
				r.woken_valid = 1'b1;
				lock_owner    = r.woken_task;
				r.status      = ST_HANDED;
			end
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mutex_reply_t want;
		if (!arst_n) begin
			replies_due.delete();
			waiters.delete();
			lock_held  = 1'b0;
			lock_owner = '0;
			fails      = 0;
			pending    = 0;
		end else begin
			if (in_valid && !in_stall) begin
				replies_due.push_back(arbitrate(fhm_kind_t'(kind), task_id));
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report($sformatf("result with nothing pending, status %0d", status));
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status) begin
						report($sformatf("status got %0d want %0d", status, want.status));
					end
					if (woken_valid !== want.woken_valid) begin
						report($sformatf("woken_valid got %0b want %0b",
							woken_valid, want.woken_valid));
					end
					if (woken_task !== want.woken_task) begin
						report($sformatf("woken_task got %0d want %0d",
							woken_task, want.woken_task));
					end
				end
			end
			pending = replies_due.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Randomized lock/unlock traffic for the FIFO hand-off mutex.
// ---------------------------------------------------------------------------
// A short scripted opening walks the mutex through every status: unlock on a
// free mutex, grant and re-grant, unlock by a stranger, a full wait queue
// with a duplicate waiter, a refusal, a chain of hand-overs and the final
// free. Random traffic follows, drawn mostly from small pools of task ids so
// that unlocks often come from the holder and the ring buffer fills, wraps
// and drains. Both sides idle in random bursts; the last stretch runs flat out.
// The checker beside the block predicts and compares; this module only
// drives stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
	import fhm_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int N_OPENING    = 24;
	localparam int N_RANDOM     = 1300;
	localparam int N_TOTAL      = N_OPENING + N_RANDOM;
	localparam int QUIET_TAIL   = 200;   // transfers at the end with no idling
	localparam int PAUSE_AT     = 700;   // sender drains the block here
	localparam int LONG_HOLD_AT = 300;   // receiver holds off after this many results
	localparam int LONG_HOLD    = 80;
	localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up

	typedef struct packed {
		fhm_kind_t         req;
		logic [TASK_W-1:0] id;
	} mutex_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid;
	logic              in_stall;
	fhm_kind_t         req_kind;
	logic [TASK_W-1:0] req_task;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic              woken_valid;
	logic [TASK_W-1:0] woken_task;
	int                fails;
	int                pending;

	mutex_req_t opening[N_OPENING];

	always #(CLK_PERIOD / 2) clk = ~clk;

	fifo_handoff_mutex_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (req_kind),
		.task_id    (req_task),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.woken_valid(woken_valid),
		.woken_task (woken_task)
	);

	fhm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (req_kind),
		.task_id    (req_task),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.woken_valid(woken_valid),
		.woken_task (woken_task),
		.fails      (fails),
		.pending    (pending)
	);

	// Offer one request and hold it until the block takes the transfer.
	task automatic offer(fhm_kind_t k, logic [TASK_W-1:0] id);
		in_valid <= 1'b1;
		req_kind <= k;
		req_task <= id;
		do @(posedge clk); while (in_stall);
	endtask

	// Wait on falling edges so the checker's count is settled when read.
	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Request side: scripted opening, then pooled random traffic.
	initial begin
		int                idx;
		int                pool_n;
		logic [TASK_W-1:0] pool[4];
		fhm_kind_t         k;
		logic [TASK_W-1:0] id;
		bit                may_idle;

		// Walk every status: stranger unlocks, fill to the brim with a
		// duplicate waiter, refuse one, re-grant the holder while full,
		// then hand over down the whole queue and free.
		opening = '{
			'{KIND_UNLOCK, 4'd5},  '{KIND_LOCK, 4'd0},    '{KIND_LOCK, 4'd0},
			'{KIND_UNLOCK, 4'd15}, '{KIND_LOCK, 4'd15},   '{KIND_LOCK, 4'd1},
			'{KIND_LOCK, 4'd2},    '{KIND_LOCK, 4'd15},   '{KIND_LOCK, 4'd3},
			'{KIND_LOCK, 4'd4},    '{KIND_LOCK, 4'd5},    '{KIND_LOCK, 4'd6},
			'{KIND_LOCK, 4'd7},    '{KIND_LOCK, 4'd0},    '{KIND_UNLOCK, 4'd0},
			'{KIND_UNLOCK, 4'd15}, '{KIND_UNLOCK, 4'd1},  '{KIND_UNLOCK, 4'd2},
			'{KIND_UNLOCK, 4'd15}, '{KIND_UNLOCK, 4'd3},  '{KIND_UNLOCK, 4'd4},
			'{KIND_UNLOCK, 4'd5},  '{KIND_UNLOCK, 4'd6},  '{KIND_UNLOCK, 4'd6}
		};
		pool_n = 1;
		pool   = '{default: '0};

		in_valid <= 1'b0;
		req_kind <= KIND_LOCK;
		req_task <= '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < N_TOTAL; idx++) begin
			if (idx < N_OPENING) begin
				k  = opening[idx].req;
				id = opening[idx].id;
			end else begin
				// Refresh the id pool now and then: tiny pools make the
				// holder unlock often, the full range is plain noise.
				if ((idx - N_OPENING) % 48 == 0) begin
					pool_n = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 4);
					foreach (pool[i]) pool[i] = TASK_W'($urandom_range(0, 15));
				end
				if (pool_n == 16) begin
					id = TASK_W'($urandom_range(0, 15));
				end else begin
					id = pool[$urandom_range(0, pool_n - 1)];
				end
				k = ($urandom_range(0, 99) < 55) ? KIND_LOCK : KIND_UNLOCK;
			end

			offer(k, id);

			// Leave every third stretch of a hundred free of gaps, and the tail.
			may_idle = (idx < N_TOTAL - QUIET_TAIL) && ((idx / 100) % 3 != 1);
			if (idx == PAUSE_AT) begin
				// Drop valid and let every expected result come back.
				in_valid <= 1'b0;
				wait_drained();
			end else if (may_idle && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("[fifo_handoff_mutex_top] OK");
		end else begin
			$display("[fifo_handoff_mutex_top] ERROR");
		end
		$finish;
	end

	// Result side: random stall bursts, one long hold-off so the block
	// backs up into its input, and no stalls over the last results.
	initial begin
		int seen;
		int run_left;
		bit stalling;
		bit hold_done;

		seen      = 0;
		run_left  = 0;
		stalling  = 1'b0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				seen++;
			end
			if (!hold_done && seen >= LONG_HOLD_AT) begin
				// Hold while the sender keeps offering.
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 17);
					stalling = (seen < N_TOTAL - QUIET_TAIL) && ((seen / 128) % 3 != 2)
						&& ($urandom_range(0, 2) == 0);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	// Watchdog: give up when no transfer happens on either side for too long.
	initial begin
		int quiet_cycles;

		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("[fifo_handoff_mutex_top] ERROR");
		$finish;
	end

endmodule
